// ===== hdl/der_ecdsa_signature_canonical_check_unit_defines.svh =====
// ----------------------------------------------------------------------------
// DER signature check assertion macros
// Concurrent assertion wrappers, empty when building for synthesis.
// ----------------------------------------------------------------------------
`ifndef DER_ECDSA_SIGNATURE_CANONICAL_CHECK_UNIT_DEFINES_SVH
`define DER_ECDSA_SIGNATURE_CANONICAL_CHECK_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// check on every edge outside reset
`define DESC_ASSERT_RUN(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// check on every edge, reset included
`define DESC_ASSERT_ALL(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DESC_ASSERT_RUN(lbl, clk, rst, prop, msg)
`define DESC_ASSERT_ALL(lbl, clk, prop, msg)
`endif

`endif

// ===== hdl/desc_pkg.sv =====
// ----------------------------------------------------------------------------
// DER signature check package
// Curve constants, DER codes, verdict codes and the front/queue/back types.
// ----------------------------------------------------------------------------
package desc_pkg;

   localparam logic [255:0] ORDER_G =
      256'hFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFEBAAEDCE6AF48A03BBFD25E8CD0364141;
   localparam logic [255:0] HALF_G = ORDER_G >> 1;

   localparam logic [7:0] DER_SEQ_TAG    = 8'h30;
   localparam logic [7:0] DER_INT_TAG    = 8'h02;
   localparam logic [7:0] MAX_PART_BYTES = 8'd33;
   localparam logic [6:0] MIN_SIG_BYTES  = 7'd8;
   localparam logic [6:0] MAX_SIG_BYTES  = 7'd72;
   localparam logic [6:0] COUNT_SAT      = 7'd127;

   // power of two so the pointers wrap on their own
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      VERDICT_INVALID   = 2'd0,
      VERDICT_CANONICAL = 2'd1,
      VERDICT_LOW_S     = 2'd2
   } verdict_type;

   // one finished signature, as handed from front to back
   typedef struct packed {
      logic         well_formed;
      logic [255:0] s_value;
   } job_type;

   typedef struct packed {
      logic    valid;
      job_type job;
   } push_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_stat_type;

   typedef struct packed {
      logic at_header;
   } front_stat_type;

endpackage

// ===== hdl/desc_front.sv =====
// ----------------------------------------------------------------------------
// DER signature parser front
// Accepts signature bytes, walks the DER layout and queues one job per frame.
// ----------------------------------------------------------------------------
module desc_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [7:0]               req_tdata,
   input  logic                     req_tlast,
   input  desc_pkg::queue_stat_type q_stat,
   output desc_pkg::push_type       push,
   output desc_pkg::front_stat_type front_stat
);
   import desc_pkg::*;

   typedef enum logic [10:0] {
      PH_HDR     = 11'b00000000001,
      PH_LEN     = 11'b00000000010,
      PH_R_TAG   = 11'b00000000100,
      PH_R_LEN   = 11'b00000001000,
      PH_R_FIRST = 11'b00000010000,
      PH_R_BODY  = 11'b00000100000,
      PH_S_TAG   = 11'b00001000000,
      PH_S_LEN   = 11'b00010000000,
      PH_S_FIRST = 11'b00100000000,
      PH_S_BODY  = 11'b01000000000,
      PH_DONE    = 11'b10000000000
   } phase_type;

   phase_type    phase_ff, phase_in;
   logic [6:0]   count_ff, count_in;
   logic [7:0]   decl_ff, decl_in;
   logic [5:0]   rem_ff, rem_in;
   logic         lz_ff, lz_in;
   logic [255:0] num_ff, num_in;
   logic         ovf_ff, ovf_in;
   logic         err_ff, err_in;

   logic         accept;
   logic         take_value;
   logic         is_r;
   logic [255:0] shifted;
   logic         ovf_shift;
   logic         shifted_ge_g;
   logic [5:0]   rem_dec;
   logic [7:0]   expect_len;

   assign req_tready   = !q_stat.full;
   assign accept       = req_tvalid && req_tready;
   assign shifted      = {num_ff[247:0], req_tdata};
   assign ovf_shift    = ovf_ff || (num_ff[255:248] != 8'd0);
   assign shifted_ge_g = (shifted >= ORDER_G);
   assign rem_dec      = (rem_ff != 6'd0) ? rem_ff - 6'd1 : 6'd0;
   assign is_r         = (phase_ff == PH_R_FIRST) || (phase_ff == PH_R_BODY);

   always_comb begin
      phase_in   = phase_ff;
      count_in   = count_ff;
      decl_in    = decl_ff;
      rem_in     = rem_ff;
      lz_in      = lz_ff;
      num_in     = num_ff;
      ovf_in     = ovf_ff;
      err_in     = err_ff;
      take_value = 1'b0;
      if (accept) begin
         if (count_ff != COUNT_SAT) begin
            count_in = count_ff + 7'd1;
         end
         if (!err_ff) begin
            unique case (phase_ff)
               PH_HDR: begin
                  if (req_tdata != DER_SEQ_TAG) err_in = 1'b1;
                  else                          phase_in = PH_LEN;
               end
               PH_LEN: begin
                  decl_in  = req_tdata;
                  phase_in = PH_R_TAG;
               end
               PH_R_TAG: begin
                  if (req_tdata != DER_INT_TAG) err_in = 1'b1;
                  else                          phase_in = PH_R_LEN;
               end
               PH_S_TAG: begin
                  if (req_tdata != DER_INT_TAG) err_in = 1'b1;
                  else                          phase_in = PH_S_LEN;
               end
               PH_R_LEN, PH_S_LEN: begin
                  if (req_tdata == 8'd0 || req_tdata > MAX_PART_BYTES) begin
                     err_in = 1'b1;
                  end else begin
                     rem_in   = req_tdata[5:0];
                     lz_in    = 1'b0;
                     ovf_in   = 1'b0;
                     num_in   = '0;
                     phase_in = (phase_ff == PH_R_LEN) ? PH_R_FIRST : PH_S_FIRST;
                  end
               end
               PH_R_FIRST, PH_S_FIRST: begin
                  // negative, or a zero that pads nothing
                  if (req_tdata[7]) begin
                     err_in = 1'b1;
                  end else if (req_tdata == 8'd0 && rem_ff <= 6'd1) begin
                     err_in = 1'b1;
                  end else begin
                     if (req_tdata == 8'd0) lz_in = 1'b1;
                     take_value = 1'b1;
                  end
               end
               PH_R_BODY, PH_S_BODY: begin
                  // a leading zero is only allowed ahead of a high bit
                  if (lz_ff && !req_tdata[7]) begin
                     err_in = 1'b1;
                  end else begin
                     lz_in      = 1'b0;
                     take_value = 1'b1;
                  end
               end
               default: err_in = 1'b1;
            endcase
            if (take_value) begin
               num_in = shifted;
               ovf_in = ovf_shift;
               rem_in = rem_dec;
               if (rem_dec != 6'd0) begin
                  phase_in = is_r ? PH_R_BODY : PH_S_BODY;
               end else if (ovf_shift || shifted_ge_g) begin
                  err_in = 1'b1;
               end else begin
                  phase_in = is_r ? PH_S_TAG : PH_DONE;
               end
            end
         end
      end
   end

   assign expect_len = {1'b0, count_in} - 8'd2;

   always_comb begin
      push.valid            = accept && req_tlast;
      push.job.s_value      = num_in;
      push.job.well_formed  = !err_in && (phase_in == PH_DONE) &&
                              (count_in >= MIN_SIG_BYTES) &&
                              (count_in <= MAX_SIG_BYTES) &&
                              (decl_in == expect_len);
   end

   assign front_stat.at_header = (phase_ff == PH_HDR) && (count_ff == 7'd0) && !err_ff;

   always_ff @(posedge clock) begin
      if (reset || (accept && req_tlast)) begin
         phase_ff <= PH_HDR;
         count_ff <= 7'd0;
         decl_ff  <= 8'd0;
         rem_ff   <= 6'd0;
         lz_ff    <= 1'b0;
         num_ff   <= '0;
         ovf_ff   <= 1'b0;
         err_ff   <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         decl_ff  <= decl_in;
         rem_ff   <= rem_in;
         lz_ff    <= lz_in;
         num_ff   <= num_in;
         ovf_ff   <= ovf_in;
         err_ff   <= err_in;
      end
   end

endmodule

// ===== hdl/desc_queue.sv =====
// ----------------------------------------------------------------------------
// DER signature job queue
// Short FIFO of finished signatures between the parser and the verdict stage.
// ----------------------------------------------------------------------------
module desc_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  desc_pkg::push_type       push,
   input  logic                     pop,
   output desc_pkg::job_type        head,
   output desc_pkg::queue_stat_type q_stat
);
   import desc_pkg::*;

   job_type                  entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wptr_ff, wptr_in;
   logic [QUEUE_PTR_W-1:0]   rptr_ff, rptr_in;
   logic [QUEUE_CNT_W-1:0]   cnt_ff, cnt_in;
   logic                     do_push;
   logic                     do_pop;

   assign q_stat.full  = (cnt_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign q_stat.empty = (cnt_ff == '0);
   assign do_push      = push.valid && !q_stat.full;
   assign do_pop       = pop && !q_stat.empty;
   assign head         = entry_ff[rptr_ff];

   always_comb begin
      wptr_in = do_push ? wptr_ff + 1'b1 : wptr_ff;
      rptr_in = do_pop  ? rptr_ff + 1'b1 : rptr_ff;
      cnt_in  = cnt_ff;
      if (do_push && !do_pop) cnt_in = cnt_ff + 1'b1;
      if (!do_push && do_pop) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wptr_ff] <= push.job;
      end
   end

endmodule

// ===== hdl/desc_back.sv =====
// ----------------------------------------------------------------------------
// DER signature verdict stage
// Pops a job, grades S against half the order and holds the verdict register.
// ----------------------------------------------------------------------------
module desc_back (
   input  logic                     clock,
   input  logic                     reset,
   input  desc_pkg::queue_stat_type q_stat,
   input  desc_pkg::job_type        head,
   output logic                     pop,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [7:0]               rsp_tdata
);
   import desc_pkg::*;

   logic        valid_ff, valid_in;
   verdict_type verdict_ff, verdict_in;

   assign pop = !q_stat.empty && (!valid_ff || rsp_tready);

   always_comb begin
      valid_in = valid_ff;
      if (rsp_tready) valid_in = 1'b0;
      if (pop)        valid_in = 1'b1;
      if (!head.well_formed)          verdict_in = VERDICT_INVALID;
      else if (head.s_value > HALF_G) verdict_in = VERDICT_CANONICAL;
      else                            verdict_in = VERDICT_LOW_S;
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= valid_in;
   end

   always_ff @(posedge clock) begin
      if (pop) verdict_ff <= verdict_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {6'd0, verdict_ff};

endmodule

// ===== hdl/der_ecdsa_signature_canonical_check_unit.sv =====
// ----------------------------------------------------------------------------
// DER ECDSA signature canonical check unit
// Takes one DER signature byte per transfer and returns one verdict per frame.
// Throughput: one byte per cycle while the job queue has room; one verdict per cycle at most.
// Path: the last byte writes its job into the queue, then the job is popped into the verdict register.
// Stalls: a held result fills the two-entry job queue, then bytes stall.
// Reset: parser back to header, queue emptied, verdict valid cleared.
// ----------------------------------------------------------------------------
`include "der_ecdsa_signature_canonical_check_unit_defines.svh"

module der_ecdsa_signature_canonical_check_unit (
   input  logic       clock,
   input  logic       reset,
   // byte stream
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] sig_byte
   input  logic       req_tlast,   // last_byte
   // verdict stream
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata    // [1:0] verdict, [7:2] zero
);
   import desc_pkg::*;

   push_type       push;
   queue_stat_type q_stat;
   front_stat_type front_stat;
   job_type        head;
   logic           pop;

   // Front: parse each byte as it is transferred, push one job on the last one.
   desc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_stat     (q_stat),
      .push       (push),
      .front_stat (front_stat)
   );

   // Queue: hold finished jobs while the verdict side is stalled.
   desc_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .pop    (pop),
      .head   (head),
      .q_stat (q_stat)
   );

   // Back: grade S and drive the verdict register.
   desc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_stat     (q_stat),
      .head       (head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // parser must be back at the header after a frame ends
   `DESC_ASSERT_RUN(a_frame_clears, clock, reset, (req_tvalid && req_tready && req_tlast) |=> front_stat.at_header, "parser not cleared after last byte")
   // a job into an idle back end is popped from the queue and then shows up as a valid result
   `DESC_ASSERT_RUN(a_job_reaches_out, clock, reset, (push.valid && q_stat.empty && !rsp_tvalid) |=> ##1 rsp_tvalid, "queued job not delivered")
   // only defined verdict codes leave the block
   `DESC_ASSERT_RUN(a_verdict_code, clock, reset, rsp_tvalid |-> (rsp_tdata != 8'd3) && (rsp_tdata[7:2] == 6'd0), "bad verdict code")
   // reset drops any pending result
   `DESC_ASSERT_ALL(a_reset_idle, clock, reset |=> !rsp_tvalid, "result valid after reset")

endmodule
